>>> rtl/fhm_pkg.sv
// Package for the FIFO handoff mutex: operation and status codes, field widths,
// and the command and status structs between controller and datapath.
// No dependencies.
package fhm_pkg;

  localparam int MAX_THREADS_DEF = 16;

  localparam int OP_W     = 2;
  localparam int TID_W    = 4;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_LOCK    = 2'd0;
  localparam logic [OP_W-1:0] OP_UNLOCK  = 2'd1;
  localparam logic [OP_W-1:0] OP_TRYLOCK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic exec;
  } fhm_cmd_t;

  typedef struct packed {
    logic out_valid;
  } fhm_sts_t;

endpackage

>>> rtl/fhm_ctrl.sv
// Controller state machine of the FIFO handoff mutex.
// Sequences accept, wait queue read and execute; depends on fhm_pkg.
module fhm_ctrl
  import fhm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_stall,
  input  fhm_sts_t sts,
  output fhm_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       slot_free;

  assign in_stall  = (state_r != S_IDLE);
  // The result register can take a new transaction when empty or being drained.
  assign slot_free = !sts.out_valid || !out_stall;

  assign cmd.load_in = (state_r == S_IDLE) && in_valid;
  assign cmd.rd_en   = (state_r == S_READ);
  assign cmd.exec    = (state_r == S_EXEC) && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_read_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> (state_r == S_EXEC))
    else $error("read step not followed by execute step");

  a_accept_leads_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> cmd.rd_en)
    else $error("accepted transaction did not start a queue read");

  a_exec_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!sts.out_valid || !out_stall))
    else $error("execute step would overwrite a pending result");
`endif

endmodule

>>> rtl/fhm_datapath.sv
// Datapath of the FIFO handoff mutex: request register, owner state, wait queue
// memory with pointers and count, and the result register. Depends on fhm_pkg.
module fhm_datapath
  import fhm_pkg::*;
#(
  parameter int MAX_THREADS = MAX_THREADS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fhm_cmd_t            cmd,
  output fhm_sts_t            sts,
  input  logic [OP_W-1:0]     in_op,
  input  logic [TID_W-1:0]    in_thread_id,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_grant_valid,
  output logic [TID_W-1:0]    out_granted_thread
);

  localparam int PW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam logic [PW-1:0] PTR_LAST  = PW'(MAX_THREADS - 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_THREADS);

  logic [TID_W-1:0]    mem [MAX_THREADS];
  logic [TID_W-1:0]    rd_data_r;

  logic [OP_W-1:0]     op_r;
  logic [TID_W-1:0]    tid_r;

  logic                owner_valid_r, owner_valid_nxt;
  logic [TID_W-1:0]    owner_id_r, owner_id_nxt;
  logic [PW-1:0]       head_ptr_r, head_ptr_nxt;
  logic [PW-1:0]       tail_ptr_r, tail_ptr_nxt;
  logic [CW-1:0]       wait_count_r, wait_count_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                grant_valid_r, grant_valid_nxt;
  logic [TID_W-1:0]    granted_r, granted_nxt;
  logic                push;

  assign sts.out_valid      = out_valid_r;
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_grant_valid    = grant_valid_r;
  assign out_granted_thread = granted_r;

  always_comb begin
    owner_valid_nxt = owner_valid_r;
    owner_id_nxt    = owner_id_r;
    head_ptr_nxt    = head_ptr_r;
    tail_ptr_nxt    = tail_ptr_r;
    wait_count_nxt  = wait_count_r;
    status_nxt      = ST_INVALID;
    grant_valid_nxt = 1'b0;
    granted_nxt     = '0;
    push            = 1'b0;
    unique case (op_r)
      OP_LOCK: begin
        if (!owner_valid_r) begin
          owner_valid_nxt = 1'b1;
          owner_id_nxt    = tid_r;
          status_nxt      = ST_OK;
        end else if (wait_count_r == COUNT_MAX) begin
          status_nxt = ST_FULL;
        end else begin
          push           = 1'b1;
          tail_ptr_nxt   = (tail_ptr_r == PTR_LAST) ? '0 : tail_ptr_r + PW'(1);
          wait_count_nxt = wait_count_r + CW'(1);
          status_nxt     = ST_BLOCKED;
        end
      end
      OP_UNLOCK: begin
        if (!owner_valid_r || owner_id_r != tid_r) begin
          status_nxt = ST_INVALID;
        end else if (wait_count_r == '0) begin
          owner_valid_nxt = 1'b0;
          owner_id_nxt    = '0;
          status_nxt      = ST_OK;
        end else begin
          // Hand ownership straight to the oldest waiter.
          head_ptr_nxt    = (head_ptr_r == PTR_LAST) ? '0 : head_ptr_r + PW'(1);
          wait_count_nxt  = wait_count_r - CW'(1);
          owner_id_nxt    = rd_data_r;
          status_nxt      = ST_OK;
          grant_valid_nxt = 1'b1;
          granted_nxt     = rd_data_r;
        end
      end
      OP_TRYLOCK: begin
        if (!owner_valid_r) begin
          owner_valid_nxt = 1'b1;
          owner_id_nxt    = tid_r;
          status_nxt      = ST_OK;
        end else begin
          status_nxt = ST_BUSY;
        end
      end
      default: begin
        status_nxt = ST_INVALID;
      end
    endcase
  end

  // Wait queue memory and payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_op;
      tid_r <= in_thread_id;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[head_ptr_r];
    end
    if (cmd.exec && push) begin
      mem[tail_ptr_r] <= tid_r;
    end
    if (cmd.exec) begin
      status_r      <= status_nxt;
      grant_valid_r <= grant_valid_nxt;
      granted_r     <= granted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_valid_r <= 1'b0;
      owner_id_r    <= '0;
      head_ptr_r    <= '0;
      tail_ptr_r    <= '0;
      wait_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.exec) begin
        owner_valid_r <= owner_valid_nxt;
        owner_id_r    <= owner_id_nxt;
        head_ptr_r    <= head_ptr_nxt;
        tail_ptr_r    <= tail_ptr_nxt;
        wait_count_r  <= wait_count_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wait_count_r <= COUNT_MAX)
    else $error("wait count exceeds queue depth");

  a_queue_needs_owner: assert property (@(posedge clk) disable iff (!rst_n)
    !owner_valid_r |-> (wait_count_r == '0))
    else $error("threads wait on a free mutex");

  a_free_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !owner_valid_r |-> (owner_id_r == '0))
    else $error("free mutex holds a nonzero owner id");

  a_grant_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && grant_valid_r) |-> (status_r == ST_OK))
    else $error("handoff reported with a status other than success");
`endif

endmodule

>>> rtl/fifo_handoff_mutex_unit.sv
// A request transaction is captured into the request register, the wait queue memory
// is then read at the head pointer into a registered read, and the execute step loads
// its result into the output register, waiting while a prior result is still stalled.
// The block takes no new request until the previous one has left the execute step.
// Reset (rst_n, synchronous, active low) frees the mutex and empties the queue;
// the queue memory itself is not cleared.
module fifo_handoff_mutex_unit
  import fhm_pkg::*;
#(
  parameter int MAX_THREADS = MAX_THREADS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_op,
  input  logic [TID_W-1:0]    in_thread_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_grant_valid,
  output logic [TID_W-1:0]    out_granted_thread
);

  // The controller walks each request transaction through three steps: capture,
  // wait queue read at the head pointer, and execute. The execute step waits until
  // the result register is free, so a pending result never gets overwritten, yet
  // the next request can be captured while the previous result is still stalled.
  fhm_cmd_t cmd;
  fhm_sts_t sts;

  fhm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds owner state, the FIFO of waiting threads and the result
  // register. An unlock by the owner with waiters hands ownership to the head entry.
  fhm_datapath #(
    .MAX_THREADS (MAX_THREADS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_op),
    .in_thread_id       (in_thread_id),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_grant_valid    (out_grant_valid),
    .out_granted_thread (out_granted_thread)
  );

endmodule

>>> tb/tb_fifo_handoff_mutex_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for fifo_handoff_mutex_unit: directed and random lock,
// unlock and trylock transactions are checked against a behavioral mutex model.
// Depends on fhm_pkg and the fifo_handoff_mutex_unit RTL.
module tb_fifo_handoff_mutex_unit;
  import fhm_pkg::*;

  // Depth of the wait queue as the block is built here.
  localparam int QUEUE_DEPTH = MAX_THREADS_DEF;
  // The fourth selector value is not an operation; the block must answer invalid.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1950;
  // The last stretch of random traffic runs with no idling on either side.
  localparam int QUIET_TAIL   = 250;
  // Slowest correct run: each transaction waits out the longest sender gap, the
  // longest result stall and the block's own work, well inside this limit.
  localparam int CYCLE_LIMIT  = 400000;
  // Extra cycles to run after the last result has come back.
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                grant_valid;
    logic [TID_W-1:0]    granted_thread;
  } mutex_result_t;

  // Mutex model plus the queue of results it has predicted but not yet seen.
  class mutex_scoreboard;
    bit               owner_valid;
    logic [TID_W-1:0] owner_id;
    logic [TID_W-1:0] wait_ring [QUEUE_DEPTH];
    int               head_idx;
    int               tail_idx;
    int               waiters;
    mutex_result_t    expected_q [$];
    int               errors;

    function new();
      owner_valid = 1'b0;
      owner_id    = '0;
      head_idx    = 0;
      tail_idx    = 0;
      waiters     = 0;
      errors      = 0;
    endfunction

    // Advances the model by one accepted request and queues its result.
    function void note_request(logic [OP_W-1:0] op, logic [TID_W-1:0] tid);
      mutex_result_t res;
      res.status         = ST_INVALID;
      res.grant_valid    = 1'b0;
      res.granted_thread = '0;
      case (op)
        OP_LOCK: begin
          if (!owner_valid) begin
            owner_valid = 1'b1;
            owner_id    = tid;
            res.status  = ST_OK;
          end else if (waiters >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            wait_ring[tail_idx] = tid;
            tail_idx            = (tail_idx + 1) % QUEUE_DEPTH;
            waiters++;
            res.status = ST_BLOCKED;
          end
        end
        OP_UNLOCK: begin
          if (!owner_valid || owner_id != tid) begin
            res.status = ST_INVALID;
          end else if (waiters == 0) begin
            owner_valid = 1'b0;
            owner_id    = '0;
            res.status  = ST_OK;
          end else begin
            owner_id           = wait_ring[head_idx];
            head_idx           = (head_idx + 1) % QUEUE_DEPTH;
            waiters--;
            res.status         = ST_OK;
            res.grant_valid    = 1'b1;
            res.granted_thread = owner_id;
          end
        end
        OP_TRYLOCK: begin
          if (!owner_valid) begin
            owner_valid = 1'b1;
            owner_id    = tid;
            res.status  = ST_OK;
          end else begin
            res.status = ST_BUSY;
          end
        end
        default: begin
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(mutex_result_t got);
      mutex_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: status=%0d grant_valid=%0d granted=%0d",
                 $time, got.status, got.grant_valid, got.granted_thread);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.grant_valid !== want.grant_valid) begin
        $display("%0t: grant_valid mismatch: expected %0d, actual %0d",
                 $time, want.grant_valid, got.grant_valid);
        errors++;
      end
      if (got.granted_thread !== want.granted_thread) begin
        $display("%0t: granted_thread mismatch: expected %0d, actual %0d",
                 $time, want.granted_thread, got.granted_thread);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     in_op;
  logic [TID_W-1:0]    in_thread_id;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic                out_grant_valid;
  logic [TID_W-1:0]    out_granted_thread;

  mutex_scoreboard sb;
  // When set, both sides insert random idle bursts.
  bit              idle_on;
  int              cycle_count;

  fifo_handoff_mutex_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_thread_id       (in_thread_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_grant_valid    (out_grant_valid),
    .out_granted_thread (out_granted_thread)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fifo_handoff_mutex_unit regression: fail");
    $finish;
  end

  // Result monitor. Signals are read in the active region right after the edge,
  // so they still hold the values that the edge itself sampled.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_status, out_grant_valid, out_granted_thread});
    end
  end

  // Receiver: stalls the result channel in random bursts while idling is on.
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Presents one request transaction and holds it until the block takes it.
  // The model is advanced at the accepting edge, so the next request can be
  // chosen from the up-to-date owner and queue state.
  task automatic send_request(logic [OP_W-1:0] op, logic [TID_W-1:0] tid);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_thread_id <= tid;
    do begin
      @(posedge clk);
    end while (in_stall);
    sb.note_request(op, tid);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random request whose mix depends on the phase: balanced, queue filling, or
  // queue draining. Most unlocks come from the real owner so that handoffs and
  // releases happen often; the rest exercise the non-owner path.
  task automatic send_random(int phase);
    int               roll;
    int               lock_w;
    int               unlock_w;
    logic [OP_W-1:0]  op;
    logic [TID_W-1:0] tid;
    roll = $urandom_range(0, 99);
    tid  = TID_W'($urandom_range(0, 15));
    case (phase)
      1: begin
        lock_w   = 70;
        unlock_w = 10;
      end
      2: begin
        lock_w   = 15;
        unlock_w = 65;
      end
      default: begin
        lock_w   = 40;
        unlock_w = 35;
      end
    endcase
    if (roll < lock_w) begin
      op = OP_LOCK;
    end else if (roll < lock_w + unlock_w) begin
      op = OP_UNLOCK;
      if (sb.owner_valid && $urandom_range(0, 9) < 8) tid = sb.owner_id;
    end else if (roll < 95) begin
      op = OP_TRYLOCK;
    end else begin
      op = OP_UNUSED;
    end
    send_request(op, tid);
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = OP_LOCK;
    in_thread_id = '0;
    idle_on      = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Requests against a free mutex come first: an unlock of a
    // free mutex, the unused selector, then a trylock that takes the mutex and
    // an unlock that releases it.
    send_request(OP_UNLOCK, 4'd0);
    send_request(OP_UNUSED, 4'd15);
    send_request(OP_TRYLOCK, 4'd15);
    send_request(OP_UNLOCK, 4'd15);
    // Thread 0 owns the mutex; a trylock is busy and a non-owner unlock is invalid.
    send_request(OP_LOCK, 4'd0);
    send_request(OP_TRYLOCK, 4'd15);
    send_request(OP_UNLOCK, 4'd15);
    // The owner locking again queues behind itself; fifteen more threads fill
    // the queue and one more lock finds it full.
    send_request(OP_LOCK, 4'd0);
    for (int t = 1; t < QUEUE_DEPTH; t++) send_request(OP_LOCK, t[TID_W-1:0]);
    send_request(OP_LOCK, 4'd15);
    // Two handoffs: first the owner to itself, then to thread 1.
    send_request(OP_UNLOCK, 4'd0);
    send_request(OP_UNLOCK, 4'd0);

    // Random part. Idling runs in stretches, with every fourth stretch quiet,
    // and stops altogether for the tail of the run.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 100) % 4 != 3);
      if (i == RANDOM_ITEMS / 2) wait_drained();
      send_random((i / 120) % 3);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("fifo_handoff_mutex_unit regression: pass");
    end else begin
      $display("fifo_handoff_mutex_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fhm_pkg.sv
rtl/fhm_ctrl.sv
rtl/fhm_datapath.sv
rtl/fifo_handoff_mutex_unit.sv
tb/tb_fifo_handoff_mutex_unit.sv
